### hw/rtl/vacuum_gripper_sequencer_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vacuum gripper sequencer
// Shorthand for clocked properties on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VACUUM_GRIPPER_SEQUENCER_UNIT_MACROS_SVH
`define VACUUM_GRIPPER_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication
`define VGS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vgs assertion failed");

// next-cycle implication
`define VGS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vgs assertion failed");

`endif

### hw/rtl/vgs_pkg.sv
// ----------------------------------------------------------------------------
// vgs_pkg
// Shared types, codes and reset values of the vacuum gripper sequencer.
// ----------------------------------------------------------------------------
package vgs_pkg;

  localparam int TICK_W  = 32;
  localparam int SPAN_W  = 16;
  localparam int CMD_W   = 2;
  localparam int PHASE_W = 3;
  localparam int CFG_IDX_W = 3;

  // opcodes
  localparam logic OP_SET    = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_NONE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SUCTION = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_VALVE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_PUMP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUCTION_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_PUMP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_VALVE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LIMIT = 3'd5;

  // register reset values
  localparam logic [SPAN_W-1:0] RST_CLOSE_VALVE   = 16'd100;
  localparam logic [SPAN_W-1:0] RST_START_PUMP    = 16'd100;
  localparam logic [TICK_W-1:0] RST_SUCTION_LIMIT = 32'd60000;
  localparam logic [SPAN_W-1:0] RST_STOP_PUMP     = 16'd100;
  localparam logic [SPAN_W-1:0] RST_OPEN_VALVE    = 16'd2000;
  localparam logic [TICK_W-1:0] RST_RELEASE_LIMIT = 32'd10000;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE        = 3'd0,
    PH_CLOSE_VALVE = 3'd1,
    PH_START_PUMP  = 3'd2,
    PH_SUCKING     = 3'd3,
    PH_STOP_PUMP   = 3'd4,
    PH_OPEN_VALVE  = 3'd5,
    PH_RELEASING   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [SPAN_W-1:0] close_valve_ticks;
    logic [SPAN_W-1:0] start_pump_ticks;
    logic [TICK_W-1:0] suction_limit_ticks;
    logic [SPAN_W-1:0] stop_pump_ticks;
    logic [SPAN_W-1:0] open_valve_ticks;
    logic [TICK_W-1:0] release_limit_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t phase;
    logic   pump_on;
    logic   valve_open;
  } result_t;

endpackage

### hw/rtl/vgs_in_if.sv
// ----------------------------------------------------------------------------
// vgs_in_if
// Input channel: valid/ready handshake with opcode, command and tick.
// ----------------------------------------------------------------------------
interface vgs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [vgs_pkg::CMD_W-1:0]   command;
  logic [vgs_pkg::TICK_W-1:0]  now_tick;

  modport source (output valid, opcode, command, now_tick, input ready);
  modport sink   (input valid, opcode, command, now_tick, output ready);
endinterface

### hw/rtl/vgs_out_if.sv
// ----------------------------------------------------------------------------
// vgs_out_if
// Result channel: valid/ready handshake with phase and drive levels.
// ----------------------------------------------------------------------------
interface vgs_out_if;
  logic                         valid;
  logic                         ready;
  logic [vgs_pkg::PHASE_W-1:0]  phase;
  logic                         pump_on;
  logic                         valve_open;

  modport source (output valid, phase, pump_on, valve_open, input ready);
  modport sink   (input valid, phase, pump_on, valve_open, output ready);
endinterface

### hw/rtl/vgs_cfg_regs.sv
// ----------------------------------------------------------------------------
// vgs_cfg_regs
// Timing register file, written by index, no read-back.
// ----------------------------------------------------------------------------
module vgs_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [vgs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vgs_pkg::TICK_W-1:0]      cfg_wdata,
  output vgs_pkg::cfg_t                   cfg
);

  vgs_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.close_valve_ticks   <= vgs_pkg::RST_CLOSE_VALVE;
      cfg_r.start_pump_ticks    <= vgs_pkg::RST_START_PUMP;
      cfg_r.suction_limit_ticks <= vgs_pkg::RST_SUCTION_LIMIT;
      cfg_r.stop_pump_ticks     <= vgs_pkg::RST_STOP_PUMP;
      cfg_r.open_valve_ticks    <= vgs_pkg::RST_OPEN_VALVE;
      cfg_r.release_limit_ticks <= vgs_pkg::RST_RELEASE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        vgs_pkg::REG_CLOSE_VALVE:
          cfg_r.close_valve_ticks <= cfg_wdata[vgs_pkg::SPAN_W-1:0];
        vgs_pkg::REG_START_PUMP:
          cfg_r.start_pump_ticks <= cfg_wdata[vgs_pkg::SPAN_W-1:0];
        vgs_pkg::REG_SUCTION_LIMIT:
          cfg_r.suction_limit_ticks <= cfg_wdata;
        vgs_pkg::REG_STOP_PUMP:
          cfg_r.stop_pump_ticks <= cfg_wdata[vgs_pkg::SPAN_W-1:0];
        vgs_pkg::REG_OPEN_VALVE:
          cfg_r.open_valve_ticks <= cfg_wdata[vgs_pkg::SPAN_W-1:0];
        vgs_pkg::REG_RELEASE_LIMIT:
          cfg_r.release_limit_ticks <= cfg_wdata;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/vgs_core.sv
// ----------------------------------------------------------------------------
// vgs_core
// Sequencer state and next-state logic; state advances on each step_en.
// ----------------------------------------------------------------------------
module vgs_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic                          opcode,
  input  logic [vgs_pkg::CMD_W-1:0]     command,
  input  logic [vgs_pkg::TICK_W-1:0]    now_tick,
  input  vgs_pkg::cfg_t                 cfg,
  output vgs_pkg::result_t              res_nxt
);

  localparam int PAD_W = vgs_pkg::TICK_W - vgs_pkg::SPAN_W;

  vgs_pkg::phase_t               phase_r,       phase_nxt;
  logic [vgs_pkg::CMD_W-1:0]     pend_r,        pend_nxt;
  logic [vgs_pkg::TICK_W-1:0]    phase_start_r, phase_start_nxt;
  logic [vgs_pkg::TICK_W-1:0]    seq_start_r,   seq_start_nxt;
  logic                          pump_r,        pump_nxt;
  logic                          valve_r,       valve_nxt;

  logic [vgs_pkg::SPAN_W-1:0]    phase_span;
  logic [vgs_pkg::TICK_W-1:0]    seq_limit;
  logic                          phase_done;
  logic                          seq_done;

  always_comb begin
    case (phase_r)
      vgs_pkg::PH_CLOSE_VALVE: phase_span = cfg.close_valve_ticks;
      vgs_pkg::PH_START_PUMP:  phase_span = cfg.start_pump_ticks;
      vgs_pkg::PH_STOP_PUMP:   phase_span = cfg.stop_pump_ticks;
      vgs_pkg::PH_OPEN_VALVE:  phase_span = cfg.open_valve_ticks;
      default:                 phase_span = '0;
    endcase
    seq_limit = (phase_r == vgs_pkg::PH_SUCKING) ? cfg.suction_limit_ticks
                                                 : cfg.release_limit_ticks;
  end

  // elapsed time in modulo-2^32 tick arithmetic
  assign phase_done = (now_tick - phase_start_r) >= {{PAD_W{1'b0}}, phase_span};
  assign seq_done   = (now_tick - seq_start_r) >= seq_limit;

  always_comb begin
    phase_nxt       = phase_r;
    pend_nxt        = pend_r;
    phase_start_nxt = phase_start_r;
    seq_start_nxt   = seq_start_r;
    pump_nxt        = pump_r;
    valve_nxt       = valve_r;
    if (opcode == vgs_pkg::OP_SET) begin
      pend_nxt = command;
    end else begin
      case (phase_r)
        vgs_pkg::PH_IDLE: begin
          if (pend_r == vgs_pkg::CMD_SUCTION) begin
            phase_nxt       = vgs_pkg::PH_CLOSE_VALVE;
            phase_start_nxt = now_tick;
            seq_start_nxt   = now_tick;
            pend_nxt        = vgs_pkg::CMD_NONE;
          end
        end
        vgs_pkg::PH_CLOSE_VALVE: begin
          valve_nxt = 1'b0;
          if (phase_done) begin
            phase_nxt       = vgs_pkg::PH_START_PUMP;
            phase_start_nxt = now_tick;
          end
        end
        vgs_pkg::PH_START_PUMP: begin
          pump_nxt = 1'b1;
          if (phase_done) begin
            phase_nxt       = vgs_pkg::PH_SUCKING;
            phase_start_nxt = now_tick;
          end
        end
        vgs_pkg::PH_SUCKING: begin
          pump_nxt  = 1'b1;
          valve_nxt = 1'b0;
          if (seq_done) begin
            phase_nxt = vgs_pkg::PH_IDLE;
            pump_nxt  = 1'b0;
            valve_nxt = 1'b0;
          end else if (pend_r == vgs_pkg::CMD_RELEASE) begin
            phase_nxt       = vgs_pkg::PH_STOP_PUMP;
            phase_start_nxt = now_tick;
            seq_start_nxt   = now_tick;
            pend_nxt        = vgs_pkg::CMD_NONE;
          end
        end
        vgs_pkg::PH_STOP_PUMP: begin
          pump_nxt = 1'b0;
          if (phase_done) begin
            phase_nxt       = vgs_pkg::PH_OPEN_VALVE;
            phase_start_nxt = now_tick;
          end
        end
        vgs_pkg::PH_OPEN_VALVE: begin
          valve_nxt = 1'b1;
          if (phase_done) begin
            phase_nxt       = vgs_pkg::PH_RELEASING;
            phase_start_nxt = now_tick;
          end
        end
        vgs_pkg::PH_RELEASING: begin
          pump_nxt  = 1'b0;
          valve_nxt = 1'b1;
          if (seq_done) begin
            phase_nxt = vgs_pkg::PH_IDLE;
            pump_nxt  = 1'b0;
            valve_nxt = 1'b0;
          end else if (pend_r == vgs_pkg::CMD_SUCTION) begin
            phase_nxt       = vgs_pkg::PH_CLOSE_VALVE;
            phase_start_nxt = now_tick;
            seq_start_nxt   = now_tick;
            pend_nxt        = vgs_pkg::CMD_NONE;
          end
        end
        default: begin
          phase_nxt = vgs_pkg::PH_IDLE;
          pump_nxt  = 1'b0;
          valve_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= vgs_pkg::PH_IDLE;
      pend_r        <= vgs_pkg::CMD_NONE;
      phase_start_r <= '0;
      seq_start_r   <= '0;
      pump_r        <= 1'b0;
      valve_r       <= 1'b0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      pend_r        <= pend_nxt;
      phase_start_r <= phase_start_nxt;
      seq_start_r   <= seq_start_nxt;
      pump_r        <= pump_nxt;
      valve_r       <= valve_nxt;
    end
  end

  assign res_nxt.phase      = phase_nxt;
  assign res_nxt.pump_on    = pump_nxt;
  assign res_nxt.valve_open = valve_nxt;

`include "vacuum_gripper_sequencer_unit_macros.svh"

  // hold phases always run with their own drive pattern
  `VGS_ASSERT_IMP(a_sucking_levels, phase_r == vgs_pkg::PH_SUCKING, pump_r && !valve_r)
  `VGS_ASSERT_IMP(a_release_levels, phase_r == vgs_pkg::PH_RELEASING, !pump_r && valve_r)
  `VGS_ASSERT_IMP(a_idle_levels, phase_r == vgs_pkg::PH_IDLE, !pump_r && !valve_r)
  // a set transaction never moves the machine
  `VGS_ASSERT_NXT(a_set_holds, step_en && (opcode == vgs_pkg::OP_SET), phase_r == $past(phase_r))

endmodule

### hw/rtl/vacuum_gripper_sequencer_unit.sv
// Stages: 2 register stages (input register, then result register); an accepted
//   transaction moves on from each register only while the result register is free.
// Throughput: one transaction per cycle unless out_ch.ready stalls; the sequencer
//   state steps as the item leaves the input register, so the next item sees it with no bubble.
// Reset (rst_n low, synchronous): both stages empty, phase idle, no pending
//   command, levels off, timing registers at their defaults.
// ----------------------------------------------------------------------------
// vacuum_gripper_sequencer_unit
// Top level: input register, sequencer core, result register, timing regs.
// ----------------------------------------------------------------------------
module vacuum_gripper_sequencer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  vgs_in_if.sink                          in_ch,
  vgs_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [vgs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vgs_pkg::TICK_W-1:0]      cfg_wdata
);

  logic                          s1_valid_r;
  logic                          s1_opcode_r;
  logic [vgs_pkg::CMD_W-1:0]     s1_command_r;
  logic [vgs_pkg::TICK_W-1:0]    s1_now_r;
  logic                          s1_fire;
  logic                          out_free;

  logic                          out_valid_r;
  vgs_pkg::result_t              out_r;
  vgs_pkg::result_t              res_nxt;
  vgs_pkg::cfg_t                 cfg;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_opcode_r  <= in_ch.opcode;
      s1_command_r <= in_ch.command;
      s1_now_r     <= in_ch.now_tick;
    end
  end

  vgs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  vgs_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (s1_fire),
    .opcode   (s1_opcode_r),
    .command  (s1_command_r),
    .now_tick (s1_now_r),
    .cfg      (cfg),
    .res_nxt  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.phase      = out_r.phase;
  assign out_ch.pump_on    = out_r.pump_on;
  assign out_ch.valve_open = out_r.valve_open;

endmodule

### tb/vacuum_gripper_sequencer_unit_checker.sv
// ----------------------------------------------------------------------------
// vacuum_gripper_sequencer_unit_checker
// Watches the input, result and register ports, keeps its own copy of the
// sequencer state and timing, predicts each result and compares it in order.
// ----------------------------------------------------------------------------
module vacuum_gripper_sequencer_unit_checker
  import vgs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  vgs_in_if                    in_ch,
  vgs_out_if                   out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_wdata,
  output int                   awaiting,
  output int                   mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t               timing;
  phase_t             cur_phase;
  logic [CMD_W-1:0]   pending;
  logic [TICK_W-1:0]  phase_mark;
  logic [TICK_W-1:0]  seq_mark;
  logic               pump;
  logic               valve;
  result_t            expected_states[$];
  int                 errs = 0;
  int                 results_seen = 0;

  task automatic report_mismatch(input string field, input int got, input int want);
    errs++;
    $display("checker: result %0d, %s: got %0d, expected %0d",
             results_seen, field, got, want);
  endtask

  function automatic bit span_done(input logic [TICK_W-1:0] now,
                                   input logic [TICK_W-1:0] since,
                                   input logic [TICK_W-1:0] span);
    logic [TICK_W-1:0] diff;
    diff = now - since;
    return diff >= span;
  endfunction

  task automatic enter_phase(input phase_t nxt, input logic [TICK_W-1:0] now,
                             input bit fresh);
    cur_phase  = nxt;
    phase_mark = now;
    if (fresh) begin
      seq_mark = now;
      pending  = CMD_NONE;
    end
  endtask

  task automatic go_idle();
    cur_phase = PH_IDLE;
    pump      = 1'b0;
    valve     = 1'b0;
  endtask

  // Levels set by a phase stick on the step where it is left, but a limit timeout clears both.
  task automatic advance_sequencer(input logic [TICK_W-1:0] now);
    case (cur_phase)
      PH_IDLE: begin
        if (pending == CMD_SUCTION) enter_phase(PH_CLOSE_VALVE, now, 1'b1);
      end
      PH_CLOSE_VALVE: begin
        valve = 1'b0;
        if (span_done(now, phase_mark, TICK_W'(timing.close_valve_ticks)))
          enter_phase(PH_START_PUMP, now, 1'b0);
      end
      PH_START_PUMP: begin
        pump = 1'b1;
        if (span_done(now, phase_mark, TICK_W'(timing.start_pump_ticks)))
          enter_phase(PH_SUCKING, now, 1'b0);
      end
      PH_SUCKING: begin
        pump  = 1'b1;
        valve = 1'b0;
        if (span_done(now, seq_mark, timing.suction_limit_ticks)) go_idle();
        else if (pending == CMD_RELEASE) enter_phase(PH_STOP_PUMP, now, 1'b1);
      end
      PH_STOP_PUMP: begin
        pump = 1'b0;
        if (span_done(now, phase_mark, TICK_W'(timing.stop_pump_ticks)))
          enter_phase(PH_OPEN_VALVE, now, 1'b0);
      end
      PH_OPEN_VALVE: begin
        valve = 1'b1;
        if (span_done(now, phase_mark, TICK_W'(timing.open_valve_ticks)))
          enter_phase(PH_RELEASING, now, 1'b0);
      end
      PH_RELEASING: begin
        pump  = 1'b0;
        valve = 1'b1;
        if (span_done(now, seq_mark, timing.release_limit_ticks)) go_idle();
        else if (pending == CMD_SUCTION) enter_phase(PH_CLOSE_VALVE, now, 1'b1);
      end
      default: begin
        go_idle();
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      timing.close_valve_ticks   = RST_CLOSE_VALVE;
      timing.start_pump_ticks    = RST_START_PUMP;
      timing.suction_limit_ticks = RST_SUCTION_LIMIT;
      timing.stop_pump_ticks     = RST_STOP_PUMP;
      timing.open_valve_ticks    = RST_OPEN_VALVE;
      timing.release_limit_ticks = RST_RELEASE_LIMIT;
      cur_phase  = PH_IDLE;
      pending    = CMD_NONE;
      phase_mark = '0;
      seq_mark   = '0;
      pump       = 1'b0;
      valve      = 1'b0;
      expected_states.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CLOSE_VALVE:   timing.close_valve_ticks   = cfg_wdata[SPAN_W-1:0];
          REG_START_PUMP:    timing.start_pump_ticks    = cfg_wdata[SPAN_W-1:0];
          REG_SUCTION_LIMIT: timing.suction_limit_ticks = cfg_wdata;
          REG_STOP_PUMP:     timing.stop_pump_ticks     = cfg_wdata[SPAN_W-1:0];
          REG_OPEN_VALVE:    timing.open_valve_ticks    = cfg_wdata[SPAN_W-1:0];
          REG_RELEASE_LIMIT: timing.release_limit_ticks = cfg_wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.opcode == OP_SET) pending = in_ch.command;
        else advance_sequencer(in_ch.now_tick);
        expected_states.push_back(result_t'{cur_phase, pump, valve});
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_states.size() == 0) begin
          report_mismatch("unexpected transaction, phase", out_ch.phase, -1);
        end else begin
          want = expected_states.pop_front();
          if (out_ch.phase !== want.phase)
            report_mismatch("phase", out_ch.phase, want.phase);
          if (out_ch.pump_on !== want.pump_on)
            report_mismatch("pump_on", out_ch.pump_on, want.pump_on);
          if (out_ch.valve_open !== want.valve_open)
            report_mismatch("valve_open", out_ch.valve_open, want.valve_open);
        end
      end
    end
    awaiting   <= expected_states.size();
    mismatches <= errs;
  end

endmodule

### tb/vacuum_gripper_sequencer_unit_tb.sv
// ----------------------------------------------------------------------------
// vacuum_gripper_sequencer_unit_tb
// Drives pick and release command sequences with advancing, wrapping ticks
// through several timing settings, with random gaps on both channels; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module vacuum_gripper_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vgs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TICK_W-1:0]    cfg_wdata;
  bit                   sink_open = 1'b0;
  bit                   quiet = 1'b0;
  int                   awaiting;
  int                   mismatches;
  int                   cycles = 0;
  int                   items_sent = 0;
  int                   settings_used = 0;
  logic [TICK_W-1:0]    tick_now = '0;

  vgs_in_if  in_ch();
  vgs_out_if out_ch();

  assign out_ch.ready = sink_open;

  vacuum_gripper_sequencer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  vacuum_gripper_sequencer_unit_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .awaiting   (awaiting),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[vacuum_gripper_sequencer_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    sink_open <= quiet || ($urandom_range(0, 99) >= 13);
  end

  task automatic send(input logic op, input logic [CMD_W-1:0] cmd,
                      input logic [TICK_W-1:0] tick);
    while (!quiet && $urandom_range(0, 99) < 13) begin
      in_ch.valid    <= 1'b0;
      in_ch.opcode   <= 1'($urandom);
      in_ch.command  <= CMD_W'($urandom);
      in_ch.now_tick <= $urandom();
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.command  <= cmd;
    in_ch.now_tick <= tick;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic set_cmd(input logic [CMD_W-1:0] cmd);
    send(OP_SET, cmd, $urandom());
  endtask

  // step the machine with the tick moved on by delta (wraps at 2^32)
  task automatic step_by(input logic [TICK_W-1:0] delta);
    tick_now = tick_now + delta;
    send(OP_UPDATE, CMD_W'($urandom), tick_now);
  endtask

  // hold the sender until every predicted result has been checked
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // junk in the upper 16 bits of the write data for the 16-bit registers must be dropped
  task automatic load_timing(input cfg_t t);
    put_reg(REG_CLOSE_VALVE,   {16'($urandom), t.close_valve_ticks});
    put_reg(REG_START_PUMP,    {16'($urandom), t.start_pump_ticks});
    put_reg(REG_SUCTION_LIMIT, t.suction_limit_ticks);
    put_reg(REG_STOP_PUMP,     {16'($urandom), t.stop_pump_ticks});
    put_reg(REG_OPEN_VALVE,    {16'($urandom), t.open_valve_ticks});
    put_reg(REG_RELEASE_LIMIT, t.release_limit_ticks);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic cfg_t pick_timing(input int unsigned span_max,
                                       input int unsigned limit_max);
    cfg_t t;
    t.close_valve_ticks   = SPAN_W'($urandom_range(0, span_max));
    t.start_pump_ticks    = SPAN_W'($urandom_range(0, span_max));
    t.suction_limit_ticks = $urandom_range(0, limit_max);
    t.stop_pump_ticks     = SPAN_W'($urandom_range(0, span_max));
    t.open_valve_ticks    = SPAN_W'($urandom_range(0, span_max));
    t.release_limit_ticks = $urandom_range(0, limit_max);
    return t;
  endfunction

  // Mostly tick steps scaled to the phase times and limits plus suction/release requests,
  // so full pick and release cycles and limit timeouts occur often.
  task automatic run_random(input int count, input int unsigned span_max,
                            input int unsigned limit_max);
    int unsigned roll;
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      if (roll < 22) begin
        if (pick < 45)      set_cmd(CMD_SUCTION);
        else if (pick < 90) set_cmd(CMD_RELEASE);
        else if (pick < 95) set_cmd(CMD_NONE);
        else                set_cmd(CMD_UNUSED);
      end else begin
        if (pick < 70)      step_by($urandom_range(0, span_max + 3));
        else if (pick < 85) step_by($urandom_range(0, limit_max + 5));
        else if (pick < 93) step_by('0);
        else                step_by($urandom());
      end
    end
  endtask

  initial begin
    cfg_t t;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_CLOSE_VALVE;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= OP_SET;
    in_ch.command  <= CMD_NONE;
    in_ch.now_tick <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset timing
    step_by('0);
    set_cmd(CMD_UNUSED);         // latched but matches nothing
    step_by(7);
    set_cmd(CMD_RELEASE);        // idle ignores release
    step_by(1);
    set_cmd(CMD_NONE);
    tick_now = 32'hFFFF_FFC0;    // phases below straddle the tick wrap
    set_cmd(CMD_SUCTION);
    step_by('0);
    set_cmd(CMD_RELEASE);        // stays latched through close valve/start pump
    step_by(RST_CLOSE_VALVE - 1);
    step_by(1);
    step_by(RST_START_PUMP);
    step_by(1);
    step_by(RST_STOP_PUMP);
    step_by(RST_OPEN_VALVE);
    set_cmd(CMD_SUCTION);
    step_by(RST_RELEASE_LIMIT);  // limit wins over the pending suction
    step_by('0);
    step_by(RST_CLOSE_VALVE);
    step_by(RST_START_PUMP);
    set_cmd(CMD_RELEASE);
    step_by(RST_SUCTION_LIMIT);  // limit wins over the pending release
    set_cmd(CMD_NONE);
    step_by(5);
    drain();

    // all phase times and limits zero
    t = '0;
    load_timing(t);
    run_random(60, 0, 0);
    drain();

    // everything at its maximum
    t = '1;
    load_timing(t);
    run_random(60, 65535, 32'hFFFF_FFF0);
    drain();

    for (int k = 0; k < 5; k++) begin
      quiet = (k == 2);
      load_timing(pick_timing(20, 150));
      run_random(150, 20, 150);
      drain();
    end
    quiet = 1'b0;

    $display("Covered %0d transactions over %0d timing settings beyond reset,",
             items_sent, settings_used);
    $display("including zero and maximum times, tick wrap and limit timeouts.");
    if (mismatches == 0) begin
      $display("[vacuum_gripper_sequencer_unit] OK");
    end else begin
      $display("[vacuum_gripper_sequencer_unit] ERROR");
    end
    $finish;
  end

endmodule
